[hw/rtl/fwf_pkg.sv]
`default_nettype none
// ============================================================================
// fwf_pkg
// Shared types and constants of the first-occurrence word filter.
// ============================================================================
package fwf_pkg;

    // Bit width of one word character
    localparam int CHAR_W = 8;

    // Depth of the character queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // One classified character beat travelling from front to back
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              word_end;
        logic              keep;
    } q_entry_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_CHR_RD,
        ST_CHR_CHK,
        ST_FULL,
        ST_CP_RD,
        ST_CP_WR
    } back_state_t;

endpackage : fwf_pkg
`default_nettype wire

[hw/rtl/first_occurrence_word_filter_core.sv]
`default_nettype none
// Takes one word character per beat, with word_end on the final byte, and
// emits each distinct word once, byte by byte with out_last on its final byte,
// in order of first occurrence; repeats emit nothing, bytes past WORD_CHARS
// are dropped, and a new word that finds all WORD_SLOTS slots in use yields a
// single beat with store_full set. Bytes that do not end a word are taken one
// per cycle through a four-beat queue while it has room; the queue stops
// draining while the engine handles a word end. At a word end the engine scans
// the stored words through one read port of the slot memory, checking each
// stored length and comparing bytes only in slots of equal length; a new word
// is then copied into the next free slot and emitted byte by byte, held while
// the result register is full. No clearing pass is needed after reset.
// ============================================================================
// first_occurrence_word_filter_core
// Duplicate-word filter: front classifier, beat queue, word engine.
// ============================================================================
module first_occurrence_word_filter_core
    import fwf_pkg::*;
#(
    parameter int WORD_SLOTS = 128,
    parameter int WORD_CHARS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CHAR_W-1:0] character,
    input  wire logic              word_end,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CHAR_W-1:0]      out_character,
    output logic                   out_last,
    output logic                   store_full
);

    logic     fq_push;
    logic     fq_full;
    q_entry_t fq_entry;
    logic     qb_valid;
    logic     qb_pop;
    q_entry_t qb_entry;

    // input classification
    fwf_front #(.WORD_CHARS(WORD_CHARS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .character (character),
        .word_end  (word_end),
        .q_push    (fq_push),
        .q_entry   (fq_entry),
        .q_full    (fq_full)
    );

    // decoupling queue
    fwf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .wr_entry (fq_entry),
        .full     (fq_full),
        .valid    (qb_valid),
        .rd_entry (qb_entry),
        .pop      (qb_pop)
    );

    // word engine and result register
    fwf_back #(.WORD_SLOTS(WORD_SLOTS), .WORD_CHARS(WORD_CHARS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qb_valid),
        .q_entry       (qb_entry),
        .q_pop         (qb_pop),
        .empty         (empty),
        .pop           (pop),
        .out_character (out_character),
        .out_last      (out_last),
        .store_full    (store_full)
    );

endmodule : first_occurrence_word_filter_core
`default_nettype wire

[hw/rtl/fwf_ram.sv]
`default_nettype none
// ============================================================================
// fwf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module fwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule : fwf_ram
`default_nettype wire

[hw/rtl/fwf_front.sv]
`default_nettype none
// ============================================================================
// fwf_front
// Input side: takes character beats, tracks word length, marks bytes past the
// word limit and drops those that carry nothing the back needs.
// ============================================================================
module fwf_front
    import fwf_pkg::*;
#(
    parameter int WORD_CHARS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CHAR_W-1:0] character,
    input  wire logic              word_end,
    output logic                   q_push,
    output q_entry_t               q_entry,
    input  wire logic              q_full
);

    localparam int LENW = $clog2(WORD_CHARS + 1);

    logic [LENW-1:0] len_reg;
    logic [LENW-1:0] len_next;
    logic            accept;
    logic            keep;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign keep   = len_reg < LENW'(WORD_CHARS);

    // bytes past the limit matter only when they end the word
    assign q_push            = accept && (keep || word_end);
    assign q_entry.character = character;
    assign q_entry.word_end  = word_end;
    assign q_entry.keep      = keep;

    // length of the word in progress, as seen at the input
    always_comb
    begin
        len_next = len_reg;
        if (accept)
        begin
            if (word_end)
            begin
                len_next = '0;
            end
            else if (keep)
            begin
                len_next = len_reg + LENW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

endmodule : fwf_front
`default_nettype wire

[hw/rtl/fwf_queue.sv]
`default_nettype none
// ============================================================================
// fwf_queue
// Short FIFO of classified character beats between front and back.
// ============================================================================
module fwf_queue
    import fwf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t wr_entry,
    output logic          full,
    output logic          valid,
    output q_entry_t      rd_entry,
    input  wire logic     pop
);

    q_entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   cnt_reg;
    logic [QUEUE_CNT_W-1:0]   cnt_next;
    logic                     do_push;
    logic                     do_pop;

    assign full     = cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign valid    = cnt_reg != '0;
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule : fwf_queue
`default_nettype wire

[hw/rtl/fwf_back.sv]
`default_nettype none
// ============================================================================
// fwf_back
// Word engine: builds the current word, scans the stored words for a match,
// then stores and emits a new word or reports a full store.
// ============================================================================
module fwf_back
    import fwf_pkg::*;
#(
    parameter int WORD_SLOTS = 128,
    parameter int WORD_CHARS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire q_entry_t          q_entry,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CHAR_W-1:0]      out_character,
    output logic                   out_last,
    output logic                   store_full
);

    localparam int LENW = $clog2(WORD_CHARS + 1);
    localparam int IDXW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int SCW  = $clog2(WORD_SLOTS + 1);
    localparam int SIW  = $clog2(WORD_SLOTS);
    localparam int SAW  = $clog2(WORD_SLOTS * WORD_CHARS);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [LENW-1:0]    cur_len_reg;
    logic [LENW-1:0]    cur_len_next;
    logic [LENW-1:0]    k_reg;
    logic [LENW-1:0]    k_next;
    logic [SCW-1:0]     s_reg;
    logic [SCW-1:0]     s_next;
    logic [SAW-1:0]     slot_base_reg;
    logic [SAW-1:0]     slot_base_next;
    logic [SCW-1:0]     count_reg;
    logic [SCW-1:0]     count_next;
    logic [SAW-1:0]     count_base_reg;
    logic [SAW-1:0]     count_base_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_full_reg;
    logic               out_load;
    logic [CHAR_W-1:0]  out_char_d;
    logic               out_last_d;
    logic               out_full_d;
    logic               out_free;

    logic               cur_we;
    logic               cur_re;
    logic [CHAR_W-1:0]  cur_rdata;
    logic               st_we;
    logic               st_re;
    logic [CHAR_W-1:0]  st_rdata;
    logic               len_we;
    logic               len_re;
    logic [LENW-1:0]    len_rdata;

    logic               len_match;
    logic               chr_match;
    logic               k_last;
    logic               scan_done;
    logic               store_is_full;

    // current word bytes
    fwf_ram #(.WIDTH(CHAR_W), .DEPTH(WORD_CHARS)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_len_reg[IDXW-1:0]),
        .wdata (q_entry.character),
        .re    (cur_re),
        .raddr (k_reg[IDXW-1:0]),
        .rdata (cur_rdata)
    );

    // stored word bytes, slot s at s*WORD_CHARS
    fwf_ram #(.WIDTH(CHAR_W), .DEPTH(WORD_SLOTS * WORD_CHARS)) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_base_reg + SAW'(k_reg)),
        .wdata (cur_rdata),
        .re    (st_re),
        .raddr (slot_base_reg + SAW'(k_reg)),
        .rdata (st_rdata)
    );

    // stored word lengths
    fwf_ram #(.WIDTH(LENW), .DEPTH(WORD_SLOTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (count_reg[SIW-1:0]),
        .wdata (cur_len_reg),
        .re    (len_re),
        .raddr (s_reg[SIW-1:0]),
        .rdata (len_rdata)
    );

    // compare terms
    assign len_match     = len_rdata == cur_len_reg;
    assign chr_match     = st_rdata == cur_rdata;
    assign k_last        = (k_reg + LENW'(1)) == cur_len_reg;
    assign scan_done     = s_reg == count_reg;
    assign store_is_full = count_reg == SCW'(WORD_SLOTS);
    assign out_free      = !out_valid_reg || pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_entry.word_end)
                begin
                    state_next = ST_LEN_RD;
                end
            end
            ST_LEN_RD:
            begin
                if (scan_done)
                begin
                    state_next = store_is_full ? ST_FULL : ST_CP_RD;
                end
                else
                begin
                    state_next = ST_LEN_CHK;
                end
            end
            ST_LEN_CHK:
            begin
                state_next = len_match ? ST_CHR_RD : ST_LEN_RD;
            end
            ST_CHR_RD:
            begin
                state_next = ST_CHR_CHK;
            end
            ST_CHR_CHK:
            begin
                if (!chr_match)
                begin
                    state_next = ST_LEN_RD;
                end
                else if (k_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CHR_RD;
                end
            end
            ST_FULL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CP_RD:
            begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                if (out_free)
                begin
                    state_next = k_last ? ST_IDLE : ST_CP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        q_pop           = 1'b0;
        cur_we          = 1'b0;
        cur_re          = 1'b0;
        st_we           = 1'b0;
        st_re           = 1'b0;
        len_we          = 1'b0;
        len_re          = 1'b0;
        out_load        = 1'b0;
        out_char_d      = '0;
        out_last_d      = 1'b0;
        out_full_d      = 1'b0;
        cur_len_next    = cur_len_reg;
        k_next          = k_reg;
        s_next          = s_reg;
        slot_base_next  = slot_base_reg;
        count_next      = count_reg;
        count_base_next = count_base_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.keep)
                    begin
                        cur_we       = 1'b1;
                        cur_len_next = cur_len_reg + LENW'(1);
                    end
                    if (q_entry.word_end)
                    begin
                        s_next         = '0;
                        slot_base_next = '0;
                    end
                end
            end
            ST_LEN_RD:
            begin
                k_next = '0;
                len_re = !scan_done;
            end
            ST_LEN_CHK:
            begin
                if (!len_match)
                begin
                    s_next         = s_reg + SCW'(1);
                    slot_base_next = slot_base_reg + SAW'(WORD_CHARS);
                end
            end
            ST_CHR_RD:
            begin
                st_re  = 1'b1;
                cur_re = 1'b1;
            end
            ST_CHR_CHK:
            begin
                if (!chr_match)
                begin
                    s_next         = s_reg + SCW'(1);
                    slot_base_next = slot_base_reg + SAW'(WORD_CHARS);
                end
                else if (k_last)
                begin
                    // repeat of a stored word: nothing to emit
                    cur_len_next = '0;
                end
                else
                begin
                    k_next = k_reg + LENW'(1);
                end
            end
            ST_FULL:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_last_d   = 1'b1;
                    out_full_d   = 1'b1;
                    cur_len_next = '0;
                end
            end
            ST_CP_RD:
            begin
                cur_re = 1'b1;
            end
            ST_CP_WR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_char_d = cur_rdata;
                    out_last_d = k_last;
                    st_we      = 1'b1;
                    if (k_last)
                    begin
                        len_we          = 1'b1;
                        count_next      = count_reg + SCW'(1);
                        count_base_next = count_base_reg + SAW'(WORD_CHARS);
                        cur_len_next    = '0;
                    end
                    else
                    begin
                        k_next = k_reg + LENW'(1);
                    end
                end
            end
            default:
            begin
                cur_len_next = '0;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_len_reg    <= '0;
            k_reg          <= '0;
            s_reg          <= '0;
            slot_base_reg  <= '0;
            count_reg      <= '0;
            count_base_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_len_reg    <= cur_len_next;
            k_reg          <= k_next;
            s_reg          <= s_next;
            slot_base_reg  <= slot_base_next;
            count_reg      <= count_next;
            count_base_reg <= count_base_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= out_char_d;
            out_last_reg <= out_last_d;
            out_full_reg <= out_full_d;
        end
    end

    assign empty         = !out_valid_reg;
    assign out_character = out_char_reg;
    assign out_last      = out_last_reg;
    assign store_full    = out_full_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SCW'(WORD_SLOTS))
        else $error("stored word count past slot limit");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= LENW'(WORD_CHARS))
        else $error("current word length past limit");

    a_dup_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHR_CHK && chr_match && k_last)
        |=> (state_reg == ST_IDLE && cur_len_reg == '0))
        else $error("duplicate word not discarded");

    a_store_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CP_WR && out_free && k_last)
        |=> (count_reg == $past(count_reg) + SCW'(1)))
        else $error("new word did not take a slot");

endmodule : fwf_back
`default_nettype wire

[sim/tb_first_occurrence_word_filter_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_first_occurrence_word_filter_core
// Self-checking bench for the duplicate-word filter. A queue of word bytes
// feeds a push/full driver; a pop/empty monitor compares every result beat
// with a behavioral model of the filter that is updated as bytes are taken.
// Covers new words, repeats, zero and all-ones bytes, words cut at the byte
// limit, words of exactly the limit, and new words arriving at a full store.
// ============================================================================
module tb_first_occurrence_word_filter_core;
    import fwf_pkg::*;

    localparam int SLOTS         = 128;
    localparam int CHARS         = 32;
    localparam int IDLE_PCT      = 37;
    localparam int TARGET_BEATS  = 380;
    localparam int STEADY_LO     = 150;
    localparam int STEADY_HI     = 240;
    localparam int QUIET_LIMIT   = 40000;
    // Worst word-end scan: every slot plus every byte of every slot
    localparam int DRAIN_CYCLES  = 2 * SLOTS * (CHARS + 1) + 4 * CHARS + 100;

    typedef logic [CHARS*CHAR_W-1:0] word_bits_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              we;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              overflow;
    } out_beat_t;

    typedef struct {
        word_bits_t bits;
        int         len;
    } vocab_entry_t;

    // DUT ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [CHAR_W-1:0] character = '0;
    logic              word_end = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [CHAR_W-1:0] out_character;
    logic              out_last;
    logic              store_full;

    // Bench state
    in_beat_t     pending_beats[$];
    out_beat_t    expected_out[$];
    vocab_entry_t vocab[$];
    logic         running = 1'b0;
    logic         push_stalled = 1'b0;
    int           beats_in = 0;
    int           errors = 0;
    int           quiet_cycles = 0;

    // Filter model state
    word_bits_t   stored_words[SLOTS];
    int           stored_lens[SLOTS];
    int           stored_total = 0;
    word_bits_t   building_word = '0;
    int           building_len = 0;

    first_occurrence_word_filter_core #(
        .WORD_SLOTS (SLOTS),
        .WORD_CHARS (CHARS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .character     (character),
        .word_end      (word_end),
        .empty         (empty),
        .pop           (pop),
        .out_character (out_character),
        .out_last      (out_last),
        .store_full    (store_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Model: take one byte, and at a word end emit the word if it is new
    task automatic advance_word_filter(input logic [CHAR_W-1:0] ch, input logic we);
        bit hit;
        int s;
        int k;
        hit = 1'b0;
        if (building_len < CHARS)
        begin
            building_word[building_len*CHAR_W +: CHAR_W] = ch;
            building_len++;
        end
        if (we)
        begin
            for (s = 0; s < stored_total; s++)
                if (stored_lens[s] == building_len && stored_words[s] == building_word)
                    hit = 1'b1;
            if (!hit && stored_total >= SLOTS)
                expected_out.push_back(out_beat_t'{'0, 1'b1, 1'b1});
            else if (!hit)
            begin
                stored_words[stored_total] = building_word;
                stored_lens[stored_total] = building_len;
                stored_total++;
                for (k = 0; k < building_len; k++)
                    expected_out.push_back(out_beat_t'{building_word[k*CHAR_W +: CHAR_W],
                                                       1'(k == building_len - 1), 1'b0});
            end
            building_word = '0;
            building_len = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h at %0t ns", what, got, want, $time);
        errors++;
    endtask

    function automatic bit word_known(input word_bits_t bits, input int len);
        foreach (vocab[i])
            if (vocab[i].len == len && vocab[i].bits == bits)
                return 1'b1;
        return 1'b0;
    endfunction

    // Queue all bytes of one word; remember its truncated form for repeats
    task automatic queue_word(input logic [CHAR_W-1:0] w[$]);
        word_bits_t bits;
        int n;
        int k;
        bits = '0;
        for (k = 0; k < w.size(); k++)
        begin
            pending_beats.push_back(in_beat_t'{w[k], 1'(k == w.size() - 1)});
            if (k < CHARS)
                bits[k*CHAR_W +: CHAR_W] = w[k];
        end
        n = (w.size() < CHARS) ? w.size() : CHARS;
        if (!word_known(bits, n))
            vocab.push_back('{bits, n});
    endtask

    // Stimulus and end of run
    initial
    begin
        logic [CHAR_W-1:0] w[$];
        int kind;
        int n;
        int k;
        int pick;
        bit first;

        // Directed: extremes, repeats, zero byte, order and length variants
        w = '{8'h41};              queue_word(w);
        w = '{8'h41};              queue_word(w);
        w = '{8'h00};              queue_word(w);
        w = '{8'hFF};              queue_word(w);
        w = '{8'h41, 8'h42};       queue_word(w);
        w = '{8'h41, 8'h42};       queue_word(w);
        w = '{8'h42, 8'h41};       queue_word(w);
        w = '{8'h55, 8'hAA, 8'h00}; queue_word(w);
        w = '{8'h00};              queue_word(w);
        w = '{8'h00, 8'h00};       queue_word(w);
        w = '{8'hFF};              queue_word(w);

        // Random words until enough bytes and the store has overflowed
        first = 1'b1;
        while (pending_beats.size() < TARGET_BEATS || vocab.size() < SLOTS + 4)
        begin
            w.delete();
            kind = $urandom_range(0, 99);
            if (first || (kind >= 20 && kind < 22))
            begin
                // long word, cut at the byte limit
                n = $urandom_range(CHARS + 1, CHARS + 8);
                for (k = 0; k < n; k++)
                    w.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            else if (kind < 20 && vocab.size() != 0)
            begin
                // repeat; a full-length word may come back with a new tail
                pick = $urandom_range(0, vocab.size() - 1);
                for (k = 0; k < vocab[pick].len; k++)
                    w.push_back(vocab[pick].bits[k*CHAR_W +: CHAR_W]);
                if (vocab[pick].len == CHARS && $urandom_range(0, 1))
                begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        w.push_back(CHAR_W'($urandom_range(0, 255)));
                end
            end
            else if (kind == 22)
            begin
                for (k = 0; k < CHARS; k++)
                    w.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    w.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            queue_word(w);
            first = 1'b0;
        end

        // Reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for all bytes taken and all results seen, then let it settle
        while (pending_beats.size() != 0 || expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("first_occurrence_word_filter_core verification clean");
        else
            $display("first_occurrence_word_filter_core verification failed");
        $finish;
    end

    // Input side: count accepted beats and feed the model
    always @(posedge clk)
    begin
        running <= rst_n;
        push_stalled <= push && full;
        if (rst_n && push && !full)
        begin
            advance_word_filter(character, word_end);
            void'(pending_beats.pop_front());
            beats_in++;
        end
    end

    // Input driver: a stalled beat stays up until taken
    always @(negedge clk)
    begin
        if (!running)
            push <= 1'b0;
        else if (push_stalled)
            push <= 1'b1;
        else if (pending_beats.size() != 0 &&
                 ((beats_in >= STEADY_LO && beats_in < STEADY_HI) ||
                  $urandom_range(0, 99) >= IDLE_PCT))
        begin
            push <= 1'b1;
            character <= pending_beats[0].ch;
            word_end <= pending_beats[0].we;
        end
        else
            push <= 1'b0;
    end

    // Result side: random pop
    always @(negedge clk)
    begin
        if (!running)
            pop <= 1'b0;
        else
            pop <= (beats_in >= STEADY_LO && beats_in < STEADY_HI) ||
                   ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor: compare each popped beat with the oldest expectation
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_out.size() == 0)
                report_mismatch("unexpected result beat", out_character, 0);
            else
            begin
                want = expected_out.pop_front();
                if (out_character !== want.ch)
                    report_mismatch("out_character", out_character, want.ch);
                if (out_last !== want.last)
                    report_mismatch("out_last", out_last, want.last);
                if (store_full !== want.overflow)
                    report_mismatch("store_full", store_full, want.overflow);
            end
        end
    end

    // Watchdog: too long with no beat moving on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TIMEOUT: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("first_occurrence_word_filter_core verification failed");
            $finish;
        end
    end

endmodule
